### sv/lmfb_pkg.sv
package lmfb_pkg;

  // Operation codes carried in in_tuser
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_CLR    = 3'd1;
  localparam logic [2:0] OP_LOAD   = 3'd2;
  localparam logic [2:0] OP_CLS    = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;
  localparam logic [2:0] OP_BRIGHT = 3'd5;
  localparam logic [2:0] OP_RAW    = 3'd6;

  // Byte source select for emitting steps
  localparam logic [2:0] SRC_ADDR   = 3'd0;
  localparam logic [2:0] SRC_ZERO   = 3'd1;
  localparam logic [2:0] SRC_ROW    = 3'd2;
  localparam logic [2:0] SRC_BRIGHT = 3'd3;
  localparam logic [2:0] SRC_DATA   = 3'd4;

  // Frame buffer actions
  localparam logic [2:0] FB_NONE  = 3'd0;
  localparam logic [2:0] FB_SET   = 3'd1;
  localparam logic [2:0] FB_CLR   = 3'd2;
  localparam logic [2:0] FB_LOAD  = 3'd3;
  localparam logic [2:0] FB_CLEAR = 3'd4;

  // Sequencing of the step counter
  localparam logic [1:0] SEQ_NEXT = 2'd0;
  localparam logic [1:0] SEQ_END  = 2'd1;
  localparam logic [1:0] SEQ_LOOP = 2'd2;

  typedef logic [3:0] pc_t;

  // Program entry points and loop target
  localparam pc_t PC_SET      = 4'd0;
  localparam pc_t PC_CLR      = 4'd1;
  localparam pc_t PC_LOAD     = 4'd2;
  localparam pc_t PC_CLS      = 4'd3;
  localparam pc_t PC_NOP      = 4'd4;
  localparam pc_t PC_FLUSH    = 4'd5;
  localparam pc_t PC_FL_ZERO  = 4'd6;
  localparam pc_t PC_FL_ROW   = 4'd7;
  localparam pc_t PC_FL_PAD   = 4'd8;
  localparam pc_t PC_BRIGHT   = 4'd9;
  localparam pc_t PC_BR_VAL   = 4'd10;
  localparam pc_t PC_RAW      = 4'd11;
  localparam pc_t PC_RAW_CMD  = 4'd12;

  typedef struct packed {
    logic       emit;
    logic [2:0] src;
    logic       start;
    logic       last;
    logic       last_at_end;
    logic [2:0] fb;
    logic       idx_clr;
    logic       idx_inc;
    logic [1:0] seq;
    pc_t        target;
  } uword_t;

  typedef struct packed {
    logic   fire;
    uword_t word;
  } lmfb_ctl_t;

  typedef struct packed {
    logic at_end;
    logic out_free;
  } lmfb_stat_t;

  // Control store
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    w = '0;
    w.seq = SEQ_END;
    unique case (pc)
      PC_SET:   w.fb = FB_SET;
      PC_CLR:   w.fb = FB_CLR;
      PC_LOAD:  w.fb = FB_LOAD;
      PC_CLS:   w.fb = FB_CLEAR;
      PC_NOP:   w.fb = FB_NONE;
      PC_FLUSH: begin
        w.emit = 1'b1; w.src = SRC_ADDR; w.start = 1'b1; w.seq = SEQ_NEXT;
      end
      PC_FL_ZERO: begin
        w.emit = 1'b1; w.src = SRC_ZERO; w.idx_clr = 1'b1; w.seq = SEQ_NEXT;
      end
      PC_FL_ROW: begin
        w.emit = 1'b1; w.src = SRC_ROW; w.seq = SEQ_NEXT;
      end
      PC_FL_PAD: begin
        w.emit = 1'b1; w.src = SRC_ZERO; w.last_at_end = 1'b1; w.idx_inc = 1'b1;
        w.seq = SEQ_LOOP; w.target = PC_FL_ROW;
      end
      PC_BRIGHT: begin
        w.emit = 1'b1; w.src = SRC_ADDR; w.start = 1'b1; w.seq = SEQ_NEXT;
      end
      PC_BR_VAL: begin
        w.emit = 1'b1; w.src = SRC_BRIGHT; w.last = 1'b1;
      end
      PC_RAW: begin
        w.emit = 1'b1; w.src = SRC_ADDR; w.start = 1'b1; w.seq = SEQ_NEXT;
      end
      PC_RAW_CMD: begin
        w.emit = 1'b1; w.src = SRC_DATA; w.last = 1'b1;
      end
      default: w.seq = SEQ_END;
    endcase
    return w;
  endfunction

  // Entry point for each operation; the unused code runs an empty step
  function automatic pc_t entry(logic [2:0] op);
    pc_t pc;
    pc = PC_NOP;
    unique case (op)
      OP_SET:    pc = PC_SET;
      OP_CLR:    pc = PC_CLR;
      OP_LOAD:   pc = PC_LOAD;
      OP_CLS:    pc = PC_CLS;
      OP_FLUSH:  pc = PC_FLUSH;
      OP_BRIGHT: pc = PC_BRIGHT;
      OP_RAW:    pc = PC_RAW;
      default:   pc = PC_NOP;
    endcase
    return pc;
  endfunction

  // Column 0 drives bit 7, column c drives bit c-1
  function automatic logic [7:0] pixel_mask(logic [2:0] c);
    logic [7:0] m;
    m = 8'h80;
    if (c != 3'd0) begin
      m = 8'h01 << (c - 3'd1);
    end
    return m;
  endfunction

endpackage

### sv/lmfb_sequencer.sv
module lmfb_sequencer
  import lmfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [2:0] op,
  input  lmfb_stat_t stat,
  output lmfb_ctl_t  ctl,
  output logic       busy
);

  logic   busy_r, busy_nxt;
  pc_t    pc_r, pc_nxt;
  uword_t word;
  logic   advance;

  // Fetch the current control word; emitting steps wait for a free output slot
  always_comb begin
    word    = ucode(pc_r);
    advance = busy_r && (!word.emit || stat.out_free);
  end

  // Step counter with conditional jump
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      pc_nxt   = entry(op);
    end else if (advance) begin
      unique case (word.seq)
        SEQ_NEXT: pc_nxt = pc_r + 4'd1;
        SEQ_LOOP: begin
          if (stat.at_end) begin
            busy_nxt = 1'b0;
          end else begin
            pc_nxt = word.target;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_NOP;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctl.fire = advance;
  assign ctl.word = word;
  assign busy     = busy_r;

endmodule

### sv/lmfb_datapath.sv
module lmfb_datapath
  import lmfb_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [4:0] col,
  input  logic [4:0] row,
  input  logic [7:0] data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  lmfb_ctl_t  ctl,
  output lmfb_stat_t stat,
  input  logic       out_tready,
  output logic       out_tvalid,
  output logic [7:0] tx_byte,
  output logic       start_before,
  output logic       last
);

  localparam int         IDXW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [4:0] RMAX  = 5'(ROWS - 1);

  logic [7:0]      rows_r [ROWS];
  logic [7:0]      addr_byte_r;
  logic [4:0]      col_r, row_r;
  logic [7:0]      data_r;
  logic [IDXW-1:0] idx_r;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_start_r, out_last_r;

  logic [4:0]      rc;
  logic [2:0]      cc;
  logic [IDXW-1:0] slot, rd_addr;
  logic [7:0]      rd_data, mask, byte_sel;
  logic            at_end, load_out;

  // Clamp coordinates and map row to its slot
  always_comb begin
    if (row_r[4]) begin
      rc = 5'd0;
    end else if (row_r > RMAX) begin
      rc = RMAX;
    end else begin
      rc = row_r;
    end
    if (col_r[4]) begin
      cc = 3'd0;
    end else if (col_r[3]) begin
      cc = 3'd7;
    end else begin
      cc = col_r[2:0];
    end
    slot    = IDXW'(RMAX - rc);
    mask    = pixel_mask(cc);
    rd_addr = (ctl.word.src == SRC_ROW) ? idx_r : slot;
    rd_data = rows_r[rd_addr];
    at_end  = (idx_r == IDXW'(ROWS - 1));
  end

  // Select the byte for an emitting step
  always_comb begin
    case (ctl.word.src)
      SRC_ADDR:   byte_sel = addr_byte_r;
      SRC_ROW:    byte_sel = rd_data;
      SRC_BRIGHT: byte_sel = {4'hE, (|data_r[7:4]) ? 4'hF : data_r[3:0]};
      SRC_DATA:   byte_sel = data_r;
      default:    byte_sel = 8'h00;
    endcase
  end

  assign load_out = ctl.fire && ctl.word.emit;

  // Capture item fields on transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r  <= col;
      row_r  <= row;
      data_r <= data;
    end
  end

  // Address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_byte_r <= 8'hE0;
    end else if (cfg_wr_en) begin
      addr_byte_r <= cfg_wr_data;
    end
  end

  // Frame buffer updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        rows_r[i] <= 8'h00;
      end
    end else if (ctl.fire) begin
      case (ctl.word.fb)
        FB_SET:  rows_r[slot] <= rd_data | mask;
        FB_CLR:  rows_r[slot] <= rd_data & ~mask;
        FB_LOAD: rows_r[slot] <= {data_r[0], data_r[7:1]};
        FB_CLEAR: begin
          for (int i = 0; i < ROWS; i++) begin
            rows_r[i] <= 8'h00;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance the flush row index
  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.word.idx_clr) begin
      idx_r <= '0;
    end else if (ctl.fire && ctl.word.idx_inc && !at_end) begin
      idx_r <= idx_r + IDXW'(1);
    end
  end

  // Output register: hold until transfer, reload on an emitting step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte_r  <= byte_sel;
      out_start_r <= ctl.word.start;
      out_last_r  <= ctl.word.last || (ctl.word.last_at_end && at_end);
    end
  end

  assign stat.at_end   = at_end;
  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign tx_byte       = out_byte_r;
  assign start_before  = out_start_r;
  assign last          = out_last_r;

endmodule

### sv/led_matrix_frame_buffer.sv
// LED matrix frame buffer: holds ROWS row bytes (cleared at reset) and turns each
// operation into bus bytes. A small control program steps one control word per
// cycle unless an emitting step waits for the output register. After a transfer
// in_tready drops while the program runs: set pixel, clear pixel, load row, clear
// screen and the unused code take one step, and no new item is taken until the
// program ends. Flush emits 2+2*ROWS bytes (18 at ROWS=8), brightness and raw
// command emit 2; an emitting step stalls while the single output register is
// full and out_tready is low. The address byte is written through cfg_wr_en/
// cfg_wr_data; the user must write it only while idle, the block does not enforce it.
module led_matrix_frame_buffer
  import lmfb_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // col[4:0], row[9:5], data[17:10], zero pad
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte[7:0]
  output logic [0:0]  out_tuser,  // start_before[0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  lmfb_ctl_t  ctl;
  lmfb_stat_t stat;
  logic       busy;
  logic       in_fire;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  lmfb_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .op      (in_tuser),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  lmfb_datapath #(
    .ROWS (ROWS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .col          (in_tdata[4:0]),
    .row          (in_tdata[9:5]),
    .data         (in_tdata[17:10]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .ctl          (ctl),
    .stat         (stat),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .tx_byte      (out_tdata),
    .start_before (out_tuser[0]),
    .last         (out_tlast)
  );

  // A transfer always starts the program, so the next cycle is busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken while program running");

  // No transaction is a single byte
  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast)
    else $error("start byte marked last");

  // Reset leaves the block idle with no pending byte
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import lmfb_pkg::*;
();

  localparam int FRAME_ROWS = 8;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] col;
    logic [4:0] row;
    logic [7:0] data;
  } frame_op_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       start_before;
    logic       last;
  } bus_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // Operations waiting for the driver, and bus bytes waiting for the monitor
  frame_op_t op_queue[$];
  bus_byte_t pending_bytes[$];

  // Shadow copy of the frame and the address register
  logic [7:0] shadow_rows[FRAME_ROWS];
  logic [7:0] shadow_addr = 8'hE0;

  int  ops_queued = 0;
  int  ops_accepted = 0;
  int  error_count = 0;

  // Driver state
  frame_op_t held_op = '0;
  bit        offering = 1'b0;
  int        send_gap = 0;
  bit        send_steady = 1'b0;

  // Monitor state
  int  recv_gap = 0;
  bit  recv_steady = 1'b0;
  int  hold_left = 0;
  bit  pressure_arm = 1'b0;
  bit  pressure_done = 1'b0;
  bit  ready_next;

  led_matrix_frame_buffer #(
    .ROWS(FRAME_ROWS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // col[4:0], row[9:5], data[17:10], zero pad
    .in_tuser   (in_tuser),     // op[2:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // tx_byte[7:0]
    .out_tuser  (out_tuser),    // start_before[0]
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic note_error(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic void queue_byte(input logic [7:0] b, input logic s, input logic l);
    bus_byte_t e;
    e.tx_byte = b;
    e.start_before = s;
    e.last = l;
    pending_bytes.push_back(e);
  endfunction

  // Apply one operation to the shadow frame and queue the bytes it sends
  task automatic predict_tx_bytes(input frame_op_t item);
    int c;
    int r;
    int slot;
    logic [7:0] mask;
    c = $signed(item.col);
    r = $signed(item.row);
    c = (c < 0) ? 0 : (c > 7) ? 7 : c;
    r = (r < 0) ? 0 : (r > FRAME_ROWS - 1) ? FRAME_ROWS - 1 : r;
    slot = FRAME_ROWS - 1 - r;
    mask = (c == 0) ? 8'h80 : (8'h01 << (c - 1));
    case (item.op)
      OP_SET: shadow_rows[slot] = shadow_rows[slot] | mask;
      OP_CLR: shadow_rows[slot] = shadow_rows[slot] & ~mask;
      OP_LOAD: shadow_rows[slot] = {item.data[0], item.data[7:1]};
      OP_CLS: begin
        for (int i = 0; i < FRAME_ROWS; i++) shadow_rows[i] = 8'h00;
      end
      OP_FLUSH: begin
        queue_byte(shadow_addr, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        for (int i = 0; i < FRAME_ROWS; i++) begin
          queue_byte(shadow_rows[i], 1'b0, 1'b0);
          queue_byte(8'h00, 1'b0, i == FRAME_ROWS - 1);
        end
      end
      OP_BRIGHT: begin
        queue_byte(shadow_addr, 1'b1, 1'b0);
        queue_byte(8'hE0 | ((item.data > 8'd15) ? 8'd15 : item.data), 1'b0, 1'b1);
      end
      OP_RAW: begin
        queue_byte(shadow_addr, 1'b1, 1'b0);
        queue_byte(item.data, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endtask

  // Mostly short gaps, a few long ones, none while in a steady stretch
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver: hold the current item until its transfer, then load the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_tx_bytes(held_op);
        ops_accepted++;
        offering = 1'b0;
        send_gap = pick_gap(send_steady);
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (op_queue.size() > 0) begin
          held_op = op_queue.pop_front();
          offering = 1'b1;
        end
      end
      in_tvalid <= offering;
      in_tdata <= {6'd0, held_op.data, held_op.row, held_op.col};
      in_tuser <= held_op.op;
    end
  end

  // Long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (pressure_arm && !pressure_done) begin
      hold_left <= 400;
      pressure_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each byte transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_bytes.size() == 0) begin
          note_error($sformatf("unexpected byte %02h start %0b last %0b",
                               out_tdata, out_tuser[0], out_tlast));
        end else begin
          bus_byte_t e;
          e = pending_bytes.pop_front();
          if (out_tdata !== e.tx_byte || out_tuser[0] !== e.start_before ||
              out_tlast !== e.last) begin
            note_error($sformatf("byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 e.tx_byte, e.start_before, e.last,
                                 out_tdata, out_tuser[0], out_tlast));
          end
        end
      end
      if (hold_left > 0) begin
        ready_next = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        recv_gap = pick_gap(recv_steady);
        if ($urandom_range(0, 49) == 0) recv_steady = !recv_steady;
      end
      out_tready <= ready_next;
    end
  end

  task automatic add_op(input logic [2:0] op, input logic [4:0] col, input logic [4:0] row,
                        input logic [7:0] data);
    frame_op_t item;
    item.op = op;
    item.col = col;
    item.row = row;
    item.data = data;
    op_queue.push_back(item);
    ops_queued++;
  endtask

  // Random operation, weighted toward pixel work with regular flushes
  task automatic add_random_op();
    int r;
    logic [2:0] op;
    logic [4:0] col;
    logic [4:0] row;
    logic [7:0] data;
    r = $urandom_range(0, 99);
    if (r < 18) op = OP_SET;
    else if (r < 30) op = OP_CLR;
    else if (r < 45) op = OP_LOAD;
    else if (r < 50) op = OP_CLS;
    else if (r < 65) op = OP_FLUSH;
    else if (r < 78) op = OP_BRIGHT;
    else if (r < 93) op = OP_RAW;
    else op = OP_UNUSED;
    col = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
    row = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
    data = (op == OP_BRIGHT && $urandom_range(0, 1)) ? 8'($urandom_range(0, 20))
                                                      : 8'($urandom_range(0, 255));
    add_op(op, col, row, data);
  endtask

  // Wait for all transfers and bytes, then let any busy step finish
  task automatic wait_idle();
    @(posedge clk);
    while (ops_accepted != ops_queued || pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    shadow_addr = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(input int count);
    @(negedge clk);
    repeat (count) add_random_op();
  endtask

  initial begin
    for (int i = 0; i < FRAME_ROWS; i++) shadow_rows[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: clamping corners, every operation, the unused code
    @(negedge clk);
    add_op(OP_FLUSH, 5'd0, 5'd0, 8'h00);
    add_op(OP_SET, 5'd0, 5'd0, 8'h00);
    add_op(OP_SET, 5'h10, 5'h10, 8'hFF);
    add_op(OP_SET, 5'd7, 5'd7, 8'h00);
    add_op(OP_SET, 5'd15, 5'd15, 8'h00);
    add_op(OP_SET, 5'd1, 5'd3, 8'h00);
    add_op(OP_SET, 5'h1F, 5'd15, 8'h00);
    add_op(OP_LOAD, 5'd0, 5'd5, 8'h01);
    add_op(OP_LOAD, 5'd0, 5'h1D, 8'hFE);
    add_op(OP_LOAD, 5'd9, 5'd2, 8'hFF);
    add_op(OP_CLR, 5'd0, 5'd0, 8'h00);
    add_op(OP_CLR, 5'd15, 5'd7, 8'h00);
    add_op(OP_FLUSH, 5'h1F, 5'h1F, 8'hFF);
    add_op(OP_BRIGHT, 5'd0, 5'd0, 8'd0);
    add_op(OP_BRIGHT, 5'd0, 5'd0, 8'd15);
    add_op(OP_BRIGHT, 5'd0, 5'd0, 8'd16);
    add_op(OP_BRIGHT, 5'd0, 5'd0, 8'hFF);
    add_op(OP_RAW, 5'd0, 5'd0, 8'h00);
    add_op(OP_RAW, 5'h1F, 5'h1F, 8'hFF);
    add_op(OP_UNUSED, 5'h15, 5'h0A, 8'hA5);
    add_op(OP_CLS, 5'h1F, 5'h1F, 8'hFF);
    add_op(OP_FLUSH, 5'd0, 5'd0, 8'h00);
    add_op(OP_RAW, 5'd3, 5'd4, 8'h5A);
    wait_idle();

    // Random phases across address settings; hold off the receiver once
    write_address(8'h00);
    pressure_arm <= 1'b1;
    run_random(40);
    wait_idle();
    write_address(8'hFF);
    run_random(40);
    wait_idle();
    write_address(8'($urandom_range(1, 254)));
    run_random(70);

    // Drain, with a bound so leftover bytes are reported
    for (int n = 0; n < 200000; n++) begin
      if (ops_accepted == ops_queued && pending_bytes.size() == 0) break;
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (ops_accepted != ops_queued || pending_bytes.size() != 0) begin
      note_error($sformatf("%0d bytes never sent", pending_bytes.size()));
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
